// File: rtl/lbp_pkg.sv
// Shared types, counter codes and the counter update function of the local predictor.
`default_nettype none

package lbp_pkg;

    // Two-bit saturating counter codes; the upper bit is the taken prediction
    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_SN = 2'b00;  // strongly not taken
    localparam t_ctr CTR_WN = 2'b01;  // weakly not taken (reset value)
    localparam t_ctr CTR_WT = 2'b10;  // weakly taken
    localparam t_ctr CTR_ST = 2'b11;  // strongly taken

    // Pipeline control shared by the history and pattern stages
    typedef struct packed {
        logic adv;  // stage registers and memory read ports advance
        logic clr;  // post-reset clearing pass in progress
    } t_lbp_ctl;

    // Counter move, steered by the direction that was predicted earlier
    function automatic t_ctr f_next_ctr(input t_ctr ctr, input logic taken, input logic pred);
        t_ctr nxt;
        begin
            if (taken == pred) begin
                if (pred) begin
                    nxt = (ctr == CTR_WT) ? CTR_ST : ctr;
                end else begin
                    nxt = (ctr == CTR_WN) ? CTR_SN : ctr;
                end
            end else if (pred) begin
                nxt = (ctr == CTR_ST) ? CTR_WT : CTR_WN;
            end else begin
                nxt = (ctr == CTR_WN) ? CTR_WT : CTR_WN;
            end
            return nxt;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/lbp_hist.sv
// History stage: local history table, its read register and same-entry forwarding.
`default_nettype none

module lbp_hist #(
    parameter int HISTORY_ENTRIES = 512,
    parameter int HISTORY_BITS    = 6,
    parameter int COUNTER_COLUMNS = 8,
    parameter int CLR_W           = 9,
    parameter int CIDX_W          = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lbp_pkg::t_lbp_ctl i_ctl,
    input  wire logic [CLR_W-1:0] i_clr_idx,
    input  wire logic             i_accept,
    input  wire logic             i_mode,
    input  wire logic [31:0]      i_pc,
    input  wire logic             i_taken,
    input  wire logic             i_pred,
    output logic                  o_s1_valid,
    output logic                  o_s1_mode,
    output logic                  o_s1_taken,
    output logic                  o_s1_pred,
    output logic [CIDX_W-1:0]     o_s1_cidx
);
    import lbp_pkg::*;

    localparam int CSH    = $clog2(COUNTER_COLUMNS);
    localparam int HIDX_W = $clog2(HISTORY_ENTRIES);

    logic [HISTORY_BITS-1:0] r_hmem [HISTORY_ENTRIES];

    logic                    r_s1_valid;
    logic                    r_s1_mode;
    logic                    r_s1_taken;
    logic                    r_s1_pred;
    logic [HIDX_W-1:0]       r_s1_hidx;
    logic [CIDX_W-1:0]       r_s1_col;
    logic [HISTORY_BITS-1:0] r_hrd;
    logic                    r_hfwd;
    logic [HISTORY_BITS-1:0] r_hfwd_val;

    logic [HIDX_W-1:0]       in_hidx;
    logic [CIDX_W-1:0]       in_col;
    logic [HISTORY_BITS-1:0] s1_hist;
    logic [HISTORY_BITS-1:0] s1_new_hist;
    logic                    s1_upd;
    logic                    clr_hit;

    // Address split: column from the low pc bits, history entry above them
    assign in_hidx = HIDX_W'(i_pc >> CSH);
    assign in_col  = CIDX_W'(i_pc) & CIDX_W'(COUNTER_COLUMNS - 1);

    // History before this item, forwarded when the previous item just rewrote it
    assign s1_hist     = r_hfwd ? r_hfwd_val : r_hrd;
    assign s1_new_hist = {s1_hist[HISTORY_BITS-2:0], r_s1_taken};
    assign s1_upd      = r_s1_valid && r_s1_mode;
    assign clr_hit     = i_ctl.clr && ({1'b0, i_clr_idx} < (CLR_W+1)'(HISTORY_ENTRIES));

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s1_valid <= i_accept;
        end
    end

    // Stage payload, table read and forward capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s1_mode  <= i_mode;
            r_s1_taken <= i_taken;
            r_s1_pred  <= i_pred;
            r_s1_hidx  <= in_hidx;
            r_s1_col   <= in_col;
            r_hrd      <= r_hmem[in_hidx];
            r_hfwd     <= s1_upd && (r_s1_hidx == in_hidx);
            r_hfwd_val <= s1_new_hist;
        end
    end

    // Table write: clearing pass, else the update leaving this stage
    always_ff @(posedge i_clk) begin
        if (clr_hit) begin
            r_hmem[i_clr_idx[HIDX_W-1:0]] <= '0;
        end else if (i_ctl.adv && s1_upd) begin
            r_hmem[r_s1_hidx] <= s1_new_hist;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_mode  = r_s1_mode;
    assign o_s1_taken = r_s1_taken;
    assign o_s1_pred  = r_s1_pred;
    assign o_s1_cidx  = (CIDX_W'(s1_hist) << CSH) | r_s1_col;

endmodule

`default_nettype wire

// File: rtl/lbp_pht.sv
// Pattern stage: counter table, its read register, forwarding and counter update.
`default_nettype none

module lbp_pht #(
    parameter int HISTORY_BITS    = 6,
    parameter int COUNTER_COLUMNS = 8,
    parameter int CLR_W           = 9,
    parameter int CIDX_W          = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lbp_pkg::t_lbp_ctl i_ctl,
    input  wire logic [CLR_W-1:0]  i_clr_idx,
    input  wire logic              i_s1_valid,
    input  wire logic              i_s1_mode,
    input  wire logic              i_s1_taken,
    input  wire logic              i_s1_pred,
    input  wire logic [CIDX_W-1:0] i_s1_cidx,
    output logic                   o_s2_valid,
    output logic                   o_s2_taken
);
    import lbp_pkg::*;

    localparam int CTR_DEPTH = COUNTER_COLUMNS << HISTORY_BITS;

    t_ctr r_cmem [CTR_DEPTH];

    logic              r_s2_valid;
    logic              r_s2_mode;
    logic              r_s2_taken;
    logic              r_s2_pred;
    logic [CIDX_W-1:0] r_s2_cidx;
    t_ctr              r_crd;
    logic              r_cfwd;
    t_ctr              r_cfwd_val;

    t_ctr              s2_ctr;
    t_ctr              s2_next;
    logic              s2_upd;
    logic              clr_hit;

    // Counter before this item, forwarded when the previous item just wrote it
    assign s2_ctr  = r_cfwd ? r_cfwd_val : r_crd;
    assign s2_next = f_next_ctr(s2_ctr, r_s2_taken, r_s2_pred);
    assign s2_upd  = r_s2_valid && r_s2_mode;
    assign clr_hit = i_ctl.clr && ({1'b0, i_clr_idx} < (CLR_W+1)'(CTR_DEPTH));

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    // Stage payload, table read and forward capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s2_mode  <= i_s1_mode;
            r_s2_taken <= i_s1_taken;
            r_s2_pred  <= i_s1_pred;
            r_s2_cidx  <= i_s1_cidx;
            r_crd      <= r_cmem[i_s1_cidx];
            r_cfwd     <= s2_upd && (r_s2_cidx == i_s1_cidx);
            r_cfwd_val <= s2_next;
        end
    end

    // Table write: clearing pass to weakly not taken, else the update leaving
    always_ff @(posedge i_clk) begin
        if (clr_hit) begin
            r_cmem[i_clr_idx[CIDX_W-1:0]] <= CTR_WN;
        end else if (i_ctl.adv && s2_upd) begin
            r_cmem[r_s2_cidx] <= s2_next;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2_taken = s2_ctr[1];

endmodule

`default_nettype wire

// File: rtl/two_level_local_branch_predictor.sv
// Top level of the two-level local-history predictor: control, clearing pass, output buffer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_mode, i_pc, i_resolved_taken,
//          |           |                           | i_predicted_taken
//  out     | output    | o_out_valid / i_out_ready | o_predict_taken
//
// One item per cycle while the skid entry is free and no clearing pass runs; a result passes
// the history read, counter read and output register in that order before it can leave.
// Same-entry forwarding between adjacent items keeps each table at one read and one write.
// After reset a clearing pass over max(HISTORY_ENTRIES, COUNTER_COLUMNS << HISTORY_BITS)
// entries (512 by default) runs with o_in_ready low; table sizes are powers of two.
// A stalled output fills one skid entry, after which the pipeline holds.
`default_nettype none

module two_level_local_branch_predictor #(
    parameter int HISTORY_ENTRIES = 512,
    parameter int HISTORY_BITS    = 6,
    parameter int COUNTER_COLUMNS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_pc,
    input  wire logic        i_resolved_taken,
    input  wire logic        i_predicted_taken,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_predict_taken
);
    import lbp_pkg::*;

    localparam int CSH       = $clog2(COUNTER_COLUMNS);
    localparam int CIDX_W    = HISTORY_BITS + CSH;
    localparam int CTR_DEPTH = COUNTER_COLUMNS << HISTORY_BITS;
    localparam int CLR_DEPTH = (HISTORY_ENTRIES > CTR_DEPTH) ? HISTORY_ENTRIES : CTR_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    t_lbp_ctl          ctl;
    logic              r_clr_busy;
    logic [CLR_W-1:0]  r_clr_cnt;
    logic              r_out_valid;
    logic              r_out_taken;
    logic              r_skid_valid;
    logic              r_skid_taken;

    logic              accept;
    logic              out_xfer;
    logic              s1_valid;
    logic              s1_mode;
    logic              s1_taken;
    logic              s1_pred;
    logic [CIDX_W-1:0] s1_cidx;
    logic              s2_valid;
    logic              s2_taken;

    // Pipeline advances while the skid entry is free
    assign ctl.adv    = !r_skid_valid;
    assign ctl.clr    = r_clr_busy;
    assign o_in_ready = ctl.adv && !r_clr_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    // Clearing pass over both tables after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    lbp_hist #(
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .HISTORY_BITS    (HISTORY_BITS),
        .COUNTER_COLUMNS (COUNTER_COLUMNS),
        .CLR_W           (CLR_W),
        .CIDX_W          (CIDX_W)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_clr_idx  (r_clr_cnt),
        .i_accept   (accept),
        .i_mode     (i_mode),
        .i_pc       (i_pc),
        .i_taken    (i_resolved_taken),
        .i_pred     (i_predicted_taken),
        .o_s1_valid (s1_valid),
        .o_s1_mode  (s1_mode),
        .o_s1_taken (s1_taken),
        .o_s1_pred  (s1_pred),
        .o_s1_cidx  (s1_cidx)
    );

    lbp_pht #(
        .HISTORY_BITS    (HISTORY_BITS),
        .COUNTER_COLUMNS (COUNTER_COLUMNS),
        .CLR_W           (CLR_W),
        .CIDX_W          (CIDX_W)
    ) u_pht (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_clr_idx  (r_clr_cnt),
        .i_s1_valid (s1_valid),
        .i_s1_mode  (s1_mode),
        .i_s1_taken (s1_taken),
        .i_s1_pred  (s1_pred),
        .i_s1_cidx  (s1_cidx),
        .o_s2_valid (s2_valid),
        .o_s2_taken (s2_taken)
    );

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (ctl.adv && s2_valid) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (ctl.adv && s2_valid) begin
            if (!r_out_valid || out_xfer) begin
                r_out_taken <= s2_taken;
            end else begin
                r_skid_taken <= s2_taken;
            end
        end else if (out_xfer && r_skid_valid) begin
            r_out_taken <= r_skid_taken;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_predict_taken = r_out_taken;

    // A held result in the skid entry always has one in front of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // The pipeline carries no item while the tables are being cleared
    a_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!s1_valid && !s2_valid && !r_out_valid))
        else $error("item in flight during clearing pass");

    // The clearing pass ends only after sweeping the full depth
    a_clear_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_cnt) == CLR_W'(CLR_DEPTH - 1)))
        else $error("clearing pass ended early");

endmodule

`default_nettype wire
